[hw/rtl/bphr_pkg.sv]
// ----------------------------------------------------------------------------
// bphr_pkg
// Shared types and constants for the button press / hold / release event block.
// ----------------------------------------------------------------------------
package bphr_pkg;

    localparam int LANES  = 8;
    localparam int PIN_W  = 8;
    localparam int IDX_W  = 3;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 8;
    localparam int MASK_W = 8;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0]  COUNT_MAX    = 8'hff;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOLD    = 2'd2;

    typedef logic [LANES-1:0][CNT_W-1:0] cnt_vec_t;

    // one classified scan tick, queued between the front and back parts
    typedef struct packed {
        logic [MASK_W-1:0] ev_mask;   // buttons that give an event this tick
        logic [MASK_W-1:0] now_mask;  // buttons pressed now
        logic [MASK_W-1:0] was_mask;  // buttons pressed before this tick
        logic [MASK_W-1:0] held_mask; // held bits after this tick
        cnt_vec_t          cnt;       // hold counters before this tick
    } tick_rec_t;

endpackage

[hw/rtl/bphr_front.sv]
// ----------------------------------------------------------------------------
// bphr_front
// Accepts scan ticks, updates the per-button state and classifies the tick.
// ----------------------------------------------------------------------------
module bphr_front #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bphr_pkg::PIN_W-1:0]   s_tdata,   // [7:0] pin_levels
    input  logic                         q_full,
    output logic                         push,
    output bphr_pkg::tick_rec_t          push_rec
);

    localparam logic [bphr_pkg::MASK_W-1:0] ACTIVE_MASK =
        bphr_pkg::MASK_W'((9'd1 << NUM_BUTTONS) - 9'd1);

    logic [bphr_pkg::MASK_W-1:0] press_reg;
    logic [bphr_pkg::MASK_W-1:0] press_next;
    logic [bphr_pkg::MASK_W-1:0] hold_reg;
    logic [bphr_pkg::MASK_W-1:0] hold_next;
    logic [bphr_pkg::CNT_W-1:0]  cnt_reg  [NUM_BUTTONS];
    logic [bphr_pkg::CNT_W-1:0]  cnt_next [NUM_BUTTONS];

    logic                        accept;
    logic [bphr_pkg::MASK_W-1:0] now_mask;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign now_mask = ~s_tdata & ACTIVE_MASK;

    always_comb begin
        press_next = now_mask;
        hold_next  = now_mask & press_reg;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (!now_mask[b]) begin
                cnt_next[b] = '0;
            end else if (press_reg[b] && cnt_reg[b] != bphr_pkg::COUNT_MAX) begin
                cnt_next[b] = cnt_reg[b] + 1'b1;
            end else begin
                cnt_next[b] = cnt_reg[b];
            end
        end
    end

    always_comb begin
        push_rec           = '0;
        push_rec.ev_mask   = now_mask | press_reg;
        push_rec.now_mask  = now_mask;
        push_rec.was_mask  = press_reg;
        push_rec.held_mask = hold_next;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            push_rec.cnt[b] = cnt_reg[b];
        end
    end

    // quiet ticks update nothing visible and are dropped here
    assign push = accept && (push_rec.ev_mask != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_reg <= '0;
            hold_reg  <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                cnt_reg[b] <= '0;
            end
        end else if (accept) begin
            press_reg <= press_next;
            hold_reg  <= hold_next;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                cnt_reg[b] <= cnt_next[b];
            end
        end
    end

`ifndef SYNTHESIS
    // hold bits only ever sit on pressed buttons
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_reg & ~press_reg) == '0)
        else $error("hold bit set on a released button");
`endif

endmodule

[hw/rtl/bphr_queue.sv]
// ----------------------------------------------------------------------------
// bphr_queue
// Two-entry queue of classified ticks between the front and back parts.
// ----------------------------------------------------------------------------
module bphr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bphr_pkg::tick_rec_t push_rec,
    output logic                full,
    output logic                q_valid,
    output bphr_pkg::tick_rec_t q_rec,
    input  logic                pop
);

    localparam logic [1:0] DEPTH = 2'd2;

    bphr_pkg::tick_rec_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == DEPTH);
    assign q_valid = (count_reg != 2'd0);
    assign q_rec   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !q_valid))
        else $error("pop from an empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != 2'd3) && ((count_reg == 2'd0) == (wr_ptr_reg == rd_ptr_reg)
            || count_reg == DEPTH))
        else $error("queue count and pointers disagree");
`endif

endmodule

[hw/rtl/bphr_back.sv]
// ----------------------------------------------------------------------------
// bphr_back
// Walks the queued tick's event mask and sends one event per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bphr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  bphr_pkg::tick_rec_t           q_rec,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bphr_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);

    logic                          cur_valid_reg;
    logic                          cur_valid_next;
    logic [bphr_pkg::MASK_W-1:0]   rem_reg;
    logic [bphr_pkg::MASK_W-1:0]   rem_next;
    bphr_pkg::tick_rec_t           rec_reg;

    logic                          out_valid_reg;
    logic [bphr_pkg::DATA_W-1:0]   out_data_reg;
    logic                          out_last_reg;

    logic [bphr_pkg::MASK_W-1:0]   sel_bit;
    logic [bphr_pkg::MASK_W-1:0]   rem_after;
    logic [bphr_pkg::IDX_W-1:0]    sel_idx;
    logic [bphr_pkg::KIND_W-1:0]   sel_kind;
    logic [bphr_pkg::CNT_W-1:0]    sel_cnt;
    logic                          is_last;
    logic                          out_ready;
    logic                          emit;
    logic                          load;
    logic [bphr_pkg::DATA_W-1:0]   ev_data;

    // lowest remaining button first
    assign sel_bit   = rem_reg & (~rem_reg + 1'b1);
    assign rem_after = rem_reg & ~sel_bit;
    assign is_last   = (rem_after == '0);

    always_comb begin
        sel_idx = '0;
        for (int i = bphr_pkg::LANES - 1; i >= 0; i--) begin
            if (rem_reg[i]) begin
                sel_idx = bphr_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        priority if (rec_reg.now_mask[sel_idx] && rec_reg.was_mask[sel_idx]) begin
            sel_kind = bphr_pkg::KIND_HOLD;
        end else if (rec_reg.now_mask[sel_idx]) begin
            sel_kind = bphr_pkg::KIND_PRESS;
        end else begin
            sel_kind = bphr_pkg::KIND_RELEASE;
        end
    end

    assign sel_cnt = (sel_kind == bphr_pkg::KIND_HOLD) ? rec_reg.cnt[sel_idx] : '0;

    assign ev_data = {3'b000, rec_reg.held_mask, rec_reg.now_mask,
                      sel_cnt, sel_kind, sel_idx};

    assign out_ready = !out_valid_reg || m_tready;
    assign emit      = cur_valid_reg && out_ready;
    assign load      = q_valid && (!cur_valid_reg || (emit && is_last));
    assign pop       = load;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        rem_next       = rem_reg;
        if (load) begin
            cur_valid_next = 1'b1;
            rem_next       = q_rec.ev_mask;
        end else if (emit) begin
            cur_valid_next = !is_last;
            rem_next       = rem_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= q_rec;
        end
        if (emit) begin
            out_data_reg <= ev_data;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            rem_reg       <= rem_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // a tick being walked always has an event left
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (rem_reg != '0))
        else $error("active tick with empty event mask");
    // remaining events are a subset of the tick's event mask
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> ((rem_reg & ~rec_reg.ev_mask) == '0))
        else $error("remaining mask outside event mask");
`endif

endmodule

[hw/rtl/button_press_hold_release_events.sv]
// ----------------------------------------------------------------------------
// button_press_hold_release_events
// Press, hold and release event detector for up to eight scanned buttons.
// ----------------------------------------------------------------------------
// Each input transaction is one scan tick of active-low pin levels. The front
// part takes a tick in every cycle while its two-entry tick queue has room,
// updates the pressed and held bits and the saturating hold counters at once,
// and queues the tick if it gives any event. The back part sends one event per
// cycle while the output is not stalled, lowest button first, through an output
// register, marking the tick's final event with tlast. A tick gives at most
// NUM_BUTTONS events and quiet ticks give none; a tick's first event passes
// through the tick queue, the back part's tick register and the output register.
module button_press_hold_release_events #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bphr_pkg::PIN_W-1:0]  s_tdata,   // [7:0] pin_levels
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] button_index, [4:3] event_kind, [12:5] hold_count,
    // [20:13] pressed_mask, [28:21] held_mask, [31:29] zero
    output logic [bphr_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tlast    // last event of the tick
);

    logic                q_full;
    logic                push;
    bphr_pkg::tick_rec_t push_rec;
    logic                q_valid;
    bphr_pkg::tick_rec_t q_rec;
    logic                pop;

    bphr_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    bphr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_rec    (q_rec),
        .pop      (pop)
    );

    bphr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rec    (q_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[dv/button_press_hold_release_events_tb.sv]
// ----------------------------------------------------------------------------
// button_press_hold_release_events_tb
// Self-checking bench for the button press / hold / release event detector.
// ----------------------------------------------------------------------------
// Scan ticks go in on the slave stream with random gaps. A behavioral model
// tracks the pressed and held bits and the hold counters and queues the events
// that each accepted tick must give. The master stream is stalled at random,
// and every event that comes out is compared field by field with the oldest
// queued one. Covers directed corner ticks, then counter saturation on one
// held button while the other buttons take mostly small random pin changes,
// with a drain pause and a gap-free stretch.
module button_press_hold_release_events_tb;

    typedef struct {
        logic [bphr_pkg::IDX_W-1:0]  idx;
        logic [bphr_pkg::KIND_W-1:0] kind;
        logic [bphr_pkg::CNT_W-1:0]  cnt;
        logic [bphr_pkg::MASK_W-1:0] pmask;
        logic [bphr_pkg::MASK_W-1:0] hmask;
        logic                        last;
    } btn_event_t;

    logic                        aclk;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [bphr_pkg::PIN_W-1:0]  s_tdata  = '1;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [bphr_pkg::DATA_W-1:0] m_tdata;
    logic                        m_tlast;

    // model state
    logic [bphr_pkg::MASK_W-1:0] press_state = '0;
    logic [bphr_pkg::MASK_W-1:0] hold_state  = '0;
    logic [bphr_pkg::CNT_W-1:0]  hold_cnt [bphr_pkg::LANES];

    btn_event_t pending_events[$];
    int         error_count = 0;
    bit         tx_no_gaps  = 1'b0;

    int rx_stall = 0;
    int rx_free  = 0;
    int rx_roll;

    button_press_hold_release_events #(
        .NUM_BUTTONS(8)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // queue the events of one accepted tick, masks taken after the whole tick
    task automatic predict_events(input logic [bphr_pkg::PIN_W-1:0] pins);
        logic [bphr_pkg::MASK_W-1:0] now;
        btn_event_t                  tick_ev[$];
        btn_event_t                  ev;
        int                          b;
        int                          k;
        now = ~pins;
        for (b = 0; b < bphr_pkg::LANES; b++) begin
            ev.idx = b[bphr_pkg::IDX_W-1:0];
            ev.cnt = '0;
            if (now[b]) begin
                if (press_state[b]) begin
                    ev.kind = bphr_pkg::KIND_HOLD;
                    ev.cnt  = hold_cnt[b];
                    hold_state[b] = 1'b1;
                    if (hold_cnt[b] != bphr_pkg::COUNT_MAX) begin
                        hold_cnt[b] = hold_cnt[b] + 1'b1;
                    end
                end else begin
                    ev.kind = bphr_pkg::KIND_PRESS;
                    press_state[b] = 1'b1;
                end
                tick_ev.push_back(ev);
            end else begin
                if (press_state[b]) begin
                    ev.kind = bphr_pkg::KIND_RELEASE;
                    tick_ev.push_back(ev);
                end
                press_state[b] = 1'b0;
                hold_state[b]  = 1'b0;
                hold_cnt[b]    = '0;
            end
        end
        for (k = 0; k < tick_ev.size(); k++) begin
            ev       = tick_ev[k];
            ev.pmask = press_state;
            ev.hmask = hold_state;
            ev.last  = (k == tick_ev.size() - 1);
            pending_events.push_back(ev);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_no_gaps || roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // called at a rising edge, returns at the edge where the tick is taken
    task automatic send_tick(input logic [bphr_pkg::PIN_W-1:0] pins);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pins;
        do @(posedge aclk); while (!s_tready);
        predict_events(pins);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event transaction %0h", m_tdata);
                error_count++;
            end else begin
                check_field("button_index", 32'(pending_events[0].idx),
                            32'(m_tdata[2:0]));
                check_field("event_kind",   32'(pending_events[0].kind),
                            32'(m_tdata[4:3]));
                check_field("hold_count",   32'(pending_events[0].cnt),
                            32'(m_tdata[12:5]));
                check_field("pressed_mask", 32'(pending_events[0].pmask),
                            32'(m_tdata[20:13]));
                check_field("held_mask",    32'(pending_events[0].hmask),
                            32'(m_tdata[28:21]));
                check_field("pad",          32'd0, 32'(m_tdata[31:29]));
                check_field("last",         32'(pending_events[0].last),
                            32'(m_tlast));
                void'(pending_events.pop_front());
            end
        end
    end

    // receiver: random stalls, occasional long stalls and stall-free stretches
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (rx_free > 0) begin
            m_tready <= 1'b1;
            rx_free  <= rx_free - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 2) begin
                m_tready <= 1'b0;
                rx_stall <= $urandom_range(10, 40);
            end else if (rx_roll < 5) begin
                m_tready <= 1'b1;
                rx_free  <= $urandom_range(20, 80);
            end else begin
                m_tready <= (rx_roll >= 30);
            end
        end
    end

    // all press, holds, all release, quiet ticks and mixed ticks
    task automatic test_directed();
        send_tick(8'hff);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'hff);
        send_tick(8'hff);
        send_tick(8'hfe);
        send_tick(8'h7f);
        send_tick(8'h7e);
        send_tick(8'haa);
        send_tick(8'h55);
        send_tick(8'h54);
        send_tick(8'h0f);
        send_tick(8'hf0);
        send_tick(8'hf0);
        send_tick(8'hff);
    endtask

    // hold button 7 past the counter top while the other buttons take
    // mostly few-bit changes, some repeats and wild ticks
    task automatic test_hold_saturation();
        logic [bphr_pkg::PIN_W-1:0] pins;
        int                         i;
        int                         roll;
        pins = 8'hff;
        for (i = 0; i < 258; i++) begin
            if (i == 129) begin
                wait_drained();
            end
            tx_no_gaps = (i >= 160 && i < 200);
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                pins = pins ^ (8'h01 << $urandom_range(0, 7));
            end else if (roll < 70) begin
                pins = pins ^ (8'h01 << $urandom_range(0, 7))
                            ^ (8'h01 << $urandom_range(0, 7));
            end else if (roll < 85) begin
                pins = pins;
            end else begin
                pins = bphr_pkg::PIN_W'($urandom_range(0, 255));
            end
            pins[7] = 1'b0;
            send_tick(pins);
        end
        tx_no_gaps = 1'b0;
        send_tick(8'hff);
    endtask

    initial begin
        int i;
        for (i = 0; i < bphr_pkg::LANES; i++) begin
            hold_cnt[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_hold_saturation();
        s_tvalid <= 1'b0;
        i = 0;
        while (pending_events.size() != 0 && i < 20000) begin
            @(posedge aclk);
            i++;
        end
        repeat (16) @(posedge aclk);
        if (pending_events.size() != 0) begin
            $error("%0d events never arrived", pending_events.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
